// ===== rtl/bncf_pkg.sv =====
package bncf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Register and position widths.
	localparam int DIM_W  = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = DIM_W;
	localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int PROD_W = CNT_W + 1;

	localparam int NEIGHBOUR_LIMIT = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_LW    = FIFO_AW + 1;

	// Configuration port.
	localparam int   ADDR_W     = 3;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Window bit = column * 3 + row; column 0 is the oldest, row 0 the top.
	localparam logic [8:0] MASK_CENTER = 9'h010;
	localparam logic [8:0] MASK_TOP    = 9'h049;
	localparam logic [8:0] MASK_BOTTOM = 9'h124;
	localparam logic [8:0] MASK_LEFT   = 9'h007;
	localparam logic [8:0] MASK_RIGHT  = 9'h1C0;

	typedef struct packed {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [PROD_W-1:0] prod;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] addr;
		logic             bot;
		logic             emit;
		logic             last;
		logic             top_out;
		logic             bot_out;
		logic             left_out;
		logic             right_out;
	} scan_t;

	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] addr;
		logic [1:0]       data;
	} wr_t;

	typedef struct packed {
		logic filtered;
		logic last;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/bncf_cfg.sv =====
module bncf_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bncf_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output bncf_pkg::cfg_t               cfg
);

	logic [bncf_pkg::DIM_W-1:0]   width_q;
	logic [bncf_pkg::DIM_W-1:0]   height_q;
	logic [bncf_pkg::DIM_W-1:0]   wr_val;
	logic [bncf_pkg::DIM_W-1:0]   wr_eff_w;
	logic [bncf_pkg::DIM_W-1:0]   wr_eff_h;
	logic [2*bncf_pkg::DIM_W-1:0] prod_new;
	logic [2*bncf_pkg::DIM_W-1:0] prod_chk;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_val = pwdata[bncf_pkg::DIM_W-1:0];

	assign wr_eff_w = bncf_pkg::clamp_dim(wr_val, bncf_pkg::DIM_W'(bncf_pkg::MAX_WIDTH));
	assign wr_eff_h = bncf_pkg::clamp_dim(wr_val, bncf_pkg::DIM_W'(bncf_pkg::MAX_HEIGHT));

	// The frame size product is refreshed together with the register, so it is
	// valid from the first item after the write.
	always_comb begin
		unique case (paddr[2])
			bncf_pkg::REG_WIDTH: begin
				prod_new = (2*bncf_pkg::DIM_W)'(wr_eff_w) * (2*bncf_pkg::DIM_W)'(cfg.h);
			end
			bncf_pkg::REG_HEIGHT: begin
				prod_new = (2*bncf_pkg::DIM_W)'(cfg.w) * (2*bncf_pkg::DIM_W)'(wr_eff_h);
			end
			default: begin
				prod_new = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bncf_pkg::DIM_W'(bncf_pkg::MAX_WIDTH);
			height_q <= bncf_pkg::DIM_W'(bncf_pkg::MAX_HEIGHT);
			cfg.w    <= bncf_pkg::DIM_W'(bncf_pkg::MAX_WIDTH);
			cfg.h    <= bncf_pkg::DIM_W'(bncf_pkg::MAX_HEIGHT);
			cfg.prod <= bncf_pkg::PROD_W'(bncf_pkg::MAX_WIDTH * bncf_pkg::MAX_HEIGHT);
		end else if (wr_en) begin
			cfg.prod <= prod_new[bncf_pkg::PROD_W-1:0];
			if (paddr[2] == bncf_pkg::REG_WIDTH) begin
				width_q <= wr_val;
				cfg.w   <= wr_eff_w;
			end else begin
				height_q <= wr_val;
				cfg.h    <= wr_eff_h;
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			bncf_pkg::REG_WIDTH:  prdata = 32'(width_q);
			bncf_pkg::REG_HEIGHT: prdata = 32'(height_q);
			default:              prdata = '0;
		endcase
	end

	assign prod_chk = (2*bncf_pkg::DIM_W)'(cfg.w) * (2*bncf_pkg::DIM_W)'(cfg.h);

	a_prod_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.prod == prod_chk[bncf_pkg::PROD_W-1:0])
		else $error("frame size product out of step with width and height");

endmodule

// ===== rtl/bncf_scan.sv =====
module bncf_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           pixel_set,
	input  logic           drain,
	input  bncf_pkg::cfg_t cfg,
	output logic           ignore,
	output bncf_pkg::scan_t info
);

	logic [bncf_pkg::COL_W-1:0]  col_q;
	logic [bncf_pkg::ROW_W-1:0]  row_q;
	logic [bncf_pkg::CNT_W-1:0]  cnt_q;
	logic                        rows_open;
	logic                        col_nz;
	logic [bncf_pkg::DIM_W-1:0]  pc;
	logic [bncf_pkg::ROW_W-1:0]  pr;
	logic [bncf_pkg::DIM_W-1:0]  col_inc;
	logic [bncf_pkg::PROD_W-1:0] cnt_inc;
	logic                        take;

	assign rows_open = row_q < cfg.h;
	assign ignore    = drain && rows_open;
	assign take      = fire && !ignore;
	assign col_nz    = col_q != '0;

	// Position of the window center column, i.e. the item before this one.
	assign pc = col_nz ? bncf_pkg::DIM_W'(col_q) - bncf_pkg::DIM_W'(1)
	                   : cfg.w - bncf_pkg::DIM_W'(1);
	assign pr = col_nz ? row_q : row_q - bncf_pkg::ROW_W'(1);

	assign col_inc = bncf_pkg::DIM_W'(col_q) + bncf_pkg::DIM_W'(1);
	assign cnt_inc = bncf_pkg::PROD_W'(cnt_q) + bncf_pkg::PROD_W'(1);

	always_comb begin
		info.addr      = col_q;
		info.bot       = rows_open && !drain && pixel_set;
		info.emit      = (row_q >= bncf_pkg::ROW_W'(2))
		                 || (row_q == bncf_pkg::ROW_W'(1) && col_nz);
		info.last      = info.emit && (cnt_inc >= cfg.prod);
		info.top_out   = pr <= bncf_pkg::ROW_W'(1);
		info.bot_out   = pr >= cfg.h;
		info.left_out  = pc == '0;
		info.right_out = pc >= (cfg.w - bncf_pkg::DIM_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (info.last) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
			end else begin
				if (col_inc >= cfg.w) begin
					col_q <= '0;
					row_q <= row_q + bncf_pkg::ROW_W'(1);
				end else begin
					col_q <= col_inc[bncf_pkg::COL_W-1:0];
				end
				if (info.emit) begin
					cnt_q <= cnt_inc[bncf_pkg::CNT_W-1:0];
				end
			end
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && info.last |=> col_q == '0 && row_q == '0 && cnt_q == '0)
		else $error("position counters not cleared after the last item of a frame");

endmodule

// ===== rtl/bncf_line_mem.sv =====
module bncf_line_mem (
	input  logic                       clk,
	input  logic                       re,
	input  logic [bncf_pkg::COL_W-1:0] raddr,
	output logic [1:0]                 rdata,
	input  bncf_pkg::wr_t              wr
);

	// Bit 1 holds the row two above, bit 0 the row just above.
	logic [1:0] mem [bncf_pkg::MAX_WIDTH];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bncf_win.sv =====
module bncf_win (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  bncf_pkg::scan_t info_in,
	input  logic [1:0]      rdata,
	output bncf_pkg::wr_t   wr,
	output logic            busy,
	output logic            push,
	output bncf_pkg::res_t  res
);

	logic                       valid_s1;
	bncf_pkg::scan_t            info_s1;
	logic                       fwd_v_q;
	logic [bncf_pkg::COL_W-1:0] fwd_addr_q;
	logic [1:0]                 fwd_data_q;
	logic [8:0]                 window_q;
	logic [1:0]                 old_col;
	logic [8:0]                 window_next;
	logic [8:0]                 mask;
	logic [8:0]                 masked;
	logic [3:0]                 count;

	// With a one-pixel row the next item reads the entry being written in the
	// same cycle, so the last write is forwarded over the memory data.
	assign old_col = (fwd_v_q && fwd_addr_q == info_s1.addr) ? fwd_data_q : rdata;

	assign window_next = {info_s1.bot, old_col[0], old_col[1], window_q[8:3]};

	assign wr.we   = valid_s1;
	assign wr.addr = info_s1.addr;
	assign wr.data = {old_col[0], info_s1.bot};

	always_comb begin
		mask = ~bncf_pkg::MASK_CENTER;
		if (info_s1.top_out) begin
			mask = mask & ~bncf_pkg::MASK_TOP;
		end
		if (info_s1.bot_out) begin
			mask = mask & ~bncf_pkg::MASK_BOTTOM;
		end
		if (info_s1.left_out) begin
			mask = mask & ~bncf_pkg::MASK_LEFT;
		end
		if (info_s1.right_out) begin
			mask = mask & ~bncf_pkg::MASK_RIGHT;
		end
	end

	assign masked = window_next & mask;

	always_comb begin
		count = '0;
		for (int i = 0; i < 9; i++) begin
			count = count + 4'(masked[i]);
		end
	end

	assign busy         = valid_s1;
	assign push         = valid_s1 && info_s1.emit;
	assign res.filtered = count > 4'(bncf_pkg::NEIGHBOUR_LIMIT);
	assign res.last     = info_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_v_q  <= 1'b0;
			window_q <= '0;
		end else begin
			valid_s1 <= take;
			if (valid_s1) begin
				fwd_v_q  <= 1'b1;
				window_q <= info_s1.last ? '0 : window_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			info_s1 <= info_in;
		end
		if (valid_s1) begin
			fwd_addr_q <= wr.addr;
			fwd_data_q <= wr.data;
		end
	end

	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && info_s1.last |=> window_q == '0)
		else $error("window not cleared after the last item of a frame");

endmodule

// ===== rtl/bncf_out_fifo.sv =====
module bncf_out_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  bncf_pkg::res_t               din,
	input  logic                         pop,
	output bncf_pkg::res_t               dout,
	output logic                         not_empty,
	output logic [bncf_pkg::FIFO_LW-1:0] level
);

	bncf_pkg::res_t               entry_q [bncf_pkg::FIFO_DEPTH];
	logic [bncf_pkg::FIFO_AW-1:0] wr_q;
	logic [bncf_pkg::FIFO_AW-1:0] rd_q;
	logic [bncf_pkg::FIFO_LW-1:0] level_q;

	assign dout      = entry_q[rd_q];
	assign not_empty = level_q != '0;
	assign level     = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + bncf_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + bncf_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + bncf_pkg::FIFO_LW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - bncf_pkg::FIFO_LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q < bncf_pkg::FIFO_LW'(bncf_pkg::FIFO_DEPTH)) || pop)
		else $error("result queue overflow");

endmodule

// ===== rtl/binary_neighbor_count_filter_top.sv =====
// A result is computed in the window stage and queued once the item one row plus
// one pixel after its own pixel completes its window. Throughput: one item per
// cycle while the result queue has room, set by the single read-modify-write of
// the line store per item; a four-entry result queue absorbs output stalls.
// Reset (arst_n, asynchronous) clears counters, window and queue; the line
// store is not cleared, as rows above the frame are always masked.
module binary_neighbor_count_filter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // [0] pixel_set, [7:1] zero
	input  logic                          s_axis_tuser,   // [0] drain
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,   // [0] filtered_bit, [7:1] zero
	output logic                          m_axis_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bncf_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	bncf_pkg::cfg_t               cfg;
	bncf_pkg::scan_t              info;
	bncf_pkg::wr_t                wr;
	bncf_pkg::res_t               res;
	bncf_pkg::res_t               res_out;
	logic                         fire;
	logic                         ignore;
	logic                         take;
	logic [1:0]                   rdata;
	logic                         busy;
	logic                         push;
	logic                         pop;
	logic [bncf_pkg::FIFO_LW-1:0] level;
	logic [bncf_pkg::FIFO_LW-1:0] committed;

	// Room must remain for the item still in the window stage.
	assign committed     = level + bncf_pkg::FIFO_LW'(busy);
	assign s_axis_tready = committed < bncf_pkg::FIFO_LW'(bncf_pkg::FIFO_DEPTH);
	assign fire          = s_axis_tvalid && s_axis_tready;
	assign take          = fire && !ignore;
	assign pop           = m_axis_tvalid && m_axis_tready;

	bncf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bncf_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.pixel_set (s_axis_tdata[0]),
		.drain     (s_axis_tuser),
		.cfg       (cfg),
		.ignore    (ignore),
		.info      (info)
	);

	bncf_line_mem u_line_mem (
		.clk   (clk),
		.re    (take),
		.raddr (info.addr),
		.rdata (rdata),
		.wr    (wr)
	);

	bncf_win u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.info_in (info),
		.rdata   (rdata),
		.wr      (wr),
		.busy    (busy),
		.push    (push),
		.res     (res)
	);

	bncf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res),
		.pop       (pop),
		.dout      (res_out),
		.not_empty (m_axis_tvalid),
		.level     (level)
	);

	assign m_axis_tdata = {7'b0, res_out.filtered};
	assign m_axis_tlast = res_out.last;

endmodule

// ===== tb/neighbor_count_checker.sv =====
`timescale 1ns / 100ps

module neighbor_count_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // [0] pixel_set, [7:1] zero
	input  logic                        s_axis_tuser,   // [0] drain
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [7:0]                  m_axis_tdata,   // [0] filtered_bit, [7:1] zero
	input  logic                        m_axis_tlast,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bncf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          pending_results
);

	localparam int REPORT_LIMIT = 100;

	bit                         row_above [bncf_pkg::MAX_WIDTH];
	bit                         row_two_above [bncf_pkg::MAX_WIDTH];
	logic [8:0]                 window_bits;
	int unsigned                next_col;
	int unsigned                next_row;
	int unsigned                results_given;
	logic [bncf_pkg::DIM_W-1:0] width_reg;
	logic [bncf_pkg::DIM_W-1:0] height_reg;
	bncf_pkg::res_t             expected_bits [$];
	bncf_pkg::res_t             oldest;
	logic [bncf_pkg::DIM_W-1:0] read_value;
	int                         errors = 0;

	function automatic int unsigned clamped(input logic [bncf_pkg::DIM_W-1:0] raw,
			input int unsigned lim);
		if (raw == '0) return 1;
		if (raw > lim) return lim;
		return raw;
	endfunction

	function automatic void restart_frame();
		window_bits = '0;
		next_col = 0;
		next_row = 0;
		results_given = 0;
	endfunction

	// Advances the window by one item unless it is an ignored drain; queues the filtered bit it completes, if any.
	function automatic void filter_pixel_item(input logic pix, input logic drn);
		int unsigned    w, h, c, mid_col, mid_row;
		logic           bot, mid, top, emit;
		logic [8:0]     mask;
		bncf_pkg::res_t res;
		w = clamped(width_reg, bncf_pkg::MAX_WIDTH);
		h = clamped(height_reg, bncf_pkg::MAX_HEIGHT);
		if (drn && next_row < h) return;
		bot = (next_row < h && !drn) ? pix : 1'b0;
		c = next_col % bncf_pkg::MAX_WIDTH;
		top = row_two_above[c];
		mid = row_above[c];
		row_two_above[c] = mid;
		row_above[c] = bot;
		window_bits = {bot, mid, top, window_bits[8:3]};
		emit = next_row >= 2 || (next_row == 1 && next_col >= 1);
		// The center of the window is the item accepted just before this one.
		if (next_col > 0) begin
			mid_col = next_col - 1;
			mid_row = next_row;
		end else begin
			mid_col = w - 1;
			mid_row = next_row - 1;
		end
		next_col++;
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
		end
		if (!emit) return;
		mask = ~bncf_pkg::MASK_CENTER;
		if (mid_row <= 1) mask &= ~bncf_pkg::MASK_TOP;
		if (mid_row >= h) mask &= ~bncf_pkg::MASK_BOTTOM;
		if (mid_col == 0) mask &= ~bncf_pkg::MASK_LEFT;
		if (mid_col >= w - 1) mask &= ~bncf_pkg::MASK_RIGHT;
		res.filtered = $countones(window_bits & mask) > bncf_pkg::NEIGHBOUR_LIMIT;
		res.last = results_given + 1 >= w * h;
		expected_bits.push_back(res);
		if (res.last) begin
			restart_frame();
		end else begin
			results_given++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bncf_pkg::MAX_WIDTH; i++) begin
				row_above[i] = 1'b0;
				row_two_above[i] = 1'b0;
			end
			restart_frame();
			width_reg = bncf_pkg::DIM_W'(bncf_pkg::MAX_WIDTH);
			height_reg = bncf_pkg::DIM_W'(bncf_pkg::MAX_HEIGHT);
			expected_bits.delete();
		end else begin
			// Results are matched before new items are queued, so that the order holds.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bits.size() == 0) begin
					if (errors < REPORT_LIMIT)
						$display("%0t: unexpected result, expected none, got tdata %h tlast %b",
							$time, m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					oldest = expected_bits.pop_front();
					if (m_axis_tdata !== {7'b0, oldest.filtered}
							|| m_axis_tlast !== oldest.last) begin
						if (errors < REPORT_LIMIT)
							$display("%0t: result mismatch, expected tdata %h tlast %b, %s %h %s %b",
								$time, {7'b0, oldest.filtered}, oldest.last,
								"got tdata", m_axis_tdata, "tlast", m_axis_tlast);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				filter_pixel_item(s_axis_tdata[0], s_axis_tuser);
			if (psel && penable && pready) begin
				read_value = (paddr[bncf_pkg::ADDR_W-1:2] == bncf_pkg::REG_WIDTH)
					? width_reg : height_reg;
				if (pwrite) begin
					if (paddr[bncf_pkg::ADDR_W-1:2] == bncf_pkg::REG_WIDTH) begin
						width_reg = pwdata[bncf_pkg::DIM_W-1:0];
					end else begin
						height_reg = pwdata[bncf_pkg::DIM_W-1:0];
					end
				end else if (prdata !== 32'(read_value)) begin
					if (errors < REPORT_LIMIT)
						$display("%0t: register read mismatch at %h, expected %h, got %h",
							$time, paddr, 32'(read_value), prdata);
					errors++;
				end
			end
		end
		fail_count <= errors;
		pending_results <= expected_bits.size();
	end

endmodule

// ===== tb/binary_neighbor_count_filter_top_test.sv =====
`timescale 1ns / 100ps

module binary_neighbor_count_filter_top_test;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int TOTAL_ITEMS   = 1550;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [bncf_pkg::ADDR_W-1:0] WIDTH_ADDR  = {bncf_pkg::REG_WIDTH, 2'b00};
	localparam logic [bncf_pkg::ADDR_W-1:0] HEIGHT_ADDR = {bncf_pkg::REG_HEIGHT, 2'b00};

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata;   // [0] pixel_set, [7:1] zero
	logic                        s_axis_tuser;   // [0] drain
	logic                        m_axis_tvalid;
	logic                        m_axis_tready;
	logic [7:0]                  m_axis_tdata;   // [0] filtered_bit, [7:1] zero
	logic                        m_axis_tlast;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bncf_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;
	int                          fail_count;
	int                          pending_results;
	int                          cycle_count = 0;
	int                          items_sent = 0;

	always #5 clk = ~clk;

	binary_neighbor_count_filter_top u_top (.*);

	neighbor_count_checker u_checker (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic int dim_of(input logic [31:0] raw, input int lim);
		logic [bncf_pkg::DIM_W-1:0] v;
		v = raw[bncf_pkg::DIM_W-1:0];
		if (v == '0) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	// Output side: ready stretches, some of them long, broken by stalls.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(150, 400)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			stall = idle_cycles();
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	task automatic send_item(input logic pix, input logic drn, input bit calm);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, pix};
		s_axis_tuser <= drn;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		gap = calm ? 0 : idle_cycles();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic apb_access(input bit wr, input logic [bncf_pkg::ADDR_W-1:0] addr,
			input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(input logic [31:0] raw_w, input logic [31:0] raw_h);
		apb_access(1'b1, WIDTH_ADDR, raw_w);
		apb_access(1'b1, HEIGHT_ADDR, raw_h);
		apb_access(1'b0, WIDTH_ADDR, 32'h0);
		apb_access(1'b0, HEIGHT_ADDR, 32'h0);
	endtask

	// One edge first, so that an item accepted at this edge shows up in the count.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A whole frame followed by exactly the flush items that push its last result out.
	task automatic run_frame(input logic [31:0] raw_w, input logic [31:0] raw_h, input int density,
			input bit calm);
		int ew, eh;
		ew = dim_of(raw_w, bncf_pkg::MAX_WIDTH);
		eh = dim_of(raw_h, bncf_pkg::MAX_HEIGHT);
		for (int i = 0; i < ew * eh; i++) begin
			if (!calm && $urandom_range(0, 24) == 0)
				send_item($urandom_range(0, 1) == 1, 1'b1, calm);
			send_item($urandom_range(0, 99) < density, 1'b0, calm);
		end
		for (int i = 0; i <= ew; i++)
			send_item($urandom_range(0, 1) == 1, $urandom_range(0, 3) != 0, calm);
	endtask

	initial begin
		int          densities [5];
		logic [31:0] raw_w;
		logic [31:0] raw_h;
		int          density;
		bit          calm;
		bit          first;
		densities = '{5, 30, 50, 70, 95};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, WIDTH_ADDR, 32'h0);
		apb_access(1'b0, HEIGHT_ADDR, 32'h0);

		// Solid 3x3 frame: corners see three set neighbors, edges five, the center eight.
		// The leading drain is ignored, and the set pixel after the last row only flushes.
		set_size(3, 3);
		send_item(1'b0, 1'b1, 1'b0);
		repeat (9) send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b0);
		repeat (3) send_item(1'b1, 1'b1, 1'b0);
		wait_idle();

		// Zero sizes act as one pixel.
		set_size(0, 0);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b0, 1'b1, 1'b0);
		wait_idle();

		// Shrink both sizes while a frame is in progress; surplus drains are ignored.
		set_size(4, 4);
		repeat (9) send_item($urandom_range(0, 1) == 1, 1'b0, 1'b0);
		wait_idle();
		set_size(3, 2);
		repeat (6) send_item(1'b0, 1'b1, 1'b0);
		wait_idle();

		// Largest width through saturation: the row wraps after 1024 pixels and the
		// first results of the flush come out; shrinking the frame then ends it.
		set_size(32'h7ff, 0);
		for (int i = 0; i < bncf_pkg::MAX_WIDTH; i++)
			send_item($urandom_range(0, 99) < 50, 1'b0, 1'b0);
		repeat (16) send_item(1'b0, 1'b1, 1'b0);
		wait_idle();
		set_size(4, 1);
		send_item(1'b0, 1'b1, 1'b0);
		wait_idle();

		first = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			calm = $urandom_range(0, 3) == 0;
			density = densities[$urandom_range(0, 4)];
			// Frames of the same size sometimes follow each other with no pause.
			if (first || $urandom_range(0, 2) != 0) begin
				first = 1'b0;
				case ($urandom_range(0, 9)) inside
					[0:6]: raw_w = $urandom_range(1, 8);
					[7:8]: raw_w = $urandom_range(9, 32);
					default: raw_w = 0;
				endcase
				case ($urandom_range(0, 9)) inside
					[0:6]: raw_h = $urandom_range(1, 8);
					[7:8]: raw_h = $urandom_range(9, 20);
					default: raw_h = 0;
				endcase
				if ($urandom_range(0, 1) == 1) begin
					raw_w = raw_w | ($urandom() & ~32'h7ff);
					raw_h = raw_h | ($urandom() & ~32'h7ff);
				end
				wait_idle();
				set_size(raw_w, raw_h);
			end
			run_frame(raw_w, raw_h, density, calm);
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
